@@ rtl/array_priority_queue_unit_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define APQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define APQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/apq_pkg.sv @@
`default_nettype none

package apq_pkg;

  localparam int DEPTH         = 16;
  localparam int ELEMENT_BITS  = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int CNT_BITS      = $clog2(DEPTH + 1);
  localparam int ACTION_BITS   = 2;
  localparam int STATUS_BITS   = 2;

  localparam logic [ACTION_BITS-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_PEEK    = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [ELEMENT_BITS-1:0]  elem;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/apq_if.sv @@
`default_nettype none

interface apq_req_if;
  logic                                valid;
  logic                                ready;
  logic [apq_pkg::ACTION_BITS-1:0]     action;
  logic [apq_pkg::ELEMENT_BITS-1:0]    in_element;
  logic [apq_pkg::PRIORITY_BITS-1:0]   in_priority;

  modport source (output valid, output action, output in_element, output in_priority,
                  input ready);
  modport sink   (input valid, input action, input in_element, input in_priority,
                  output ready);
endinterface

interface apq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [apq_pkg::STATUS_BITS-1:0]     status;
  logic [apq_pkg::ELEMENT_BITS-1:0]    out_element;
  logic [apq_pkg::PRIORITY_BITS-1:0]   out_priority;
  logic [apq_pkg::CNT_BITS-1:0]        fill_level;

  modport source (output valid, output status, output out_element, output out_priority,
                  output fill_level, input ready);
  modport sink   (input valid, input status, input out_element, input out_priority,
                  input fill_level, output ready);
endinterface

`default_nettype wire

@@ rtl/apq_cell.sv @@
`default_nettype none

module apq_cell (
  input  wire                  clk_i,
  input  apq_pkg::cell_ctrl_t  ctrl_i,
  input  wire                  occupied_i,
  input  wire                  left_ahead_i,
  input  apq_pkg::entry_t      left_entry_i,
  input  apq_pkg::entry_t      right_entry_i,
  output apq_pkg::entry_t      entry_o,
  output logic                 ahead_o
);
  import apq_pkg::*;

  entry_t entry_q, entry_d;

  // stays in front of a new entry: ties keep the older one first
  assign ahead_o = occupied_i && (entry_q.prio >= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (ahead_o) begin
        entry_d = entry_q;
      end else if (left_ahead_i) begin
        entry_d = ctrl_i.new_entry;
      end else begin
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ rtl/array_priority_queue_unit.sv @@
// array_priority_queue_unit: bounded priority queue of (element, priority) pairs
//
// req_i carries one request per transfer: enqueue, dequeue highest or peek
// highest. rsp_o returns exactly one result per request: status, the element
// and priority removed or peeked (zero otherwise) and the fill level after it.
// Entries live in a row of cells kept in descending priority order, equal
// priorities in arrival order, so the head cell always holds the winner.
// An enqueue moves every cell at once: a cell keeps its entry, takes the new
// one or takes its left neighbor's; a dequeue shifts the row one cell toward
// the head. The result is registered and appears in the cycle after the
// request transfer. Throughput: one request per cycle while the receiver
// keeps up, set by the chain update; the response register is the only
// buffer between the two channels. When the receiver stalls, the result is
// held and req_i.ready drops until the result transfers. Reset empties the
// queue and clears the response valid; stored entries are not cleared, only
// cells below the count are read.
`default_nettype none

module array_priority_queue_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  apq_req_if.sink      req_i,
  apq_rsp_if.source    rsp_o
);
  import apq_pkg::*;

  logic [CNT_BITS-1:0]    count_q, count_d;
  logic                   rsp_valid_q;
  logic [STATUS_BITS-1:0] status_q, status_d;
  entry_t                 out_q, out_d;

  logic       fire;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  // chain wiring
  entry_t     cell_entry [DEPTH];
  logic       cell_ahead [DEPTH];

  assign full  = (count_q == CNT_BITS'(DEPTH));
  assign empty = (count_q == '0);

  // response register frees when its result transfers
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  // request decode
  always_comb begin
    ctrl.enq            = 1'b0;
    ctrl.deq            = 1'b0;
    ctrl.new_entry.elem = req_i.in_element;
    ctrl.new_entry.prio = req_i.in_priority;
    status_d            = ST_OK;
    out_d               = '0;
    count_d             = count_q;
    unique case (req_i.action) inside
      ACT_ENQUEUE: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          ctrl.enq = fire;
          count_d  = count_q + CNT_BITS'(1);
        end
      end
      ACT_DEQUEUE, ACT_PEEK: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          // head cell holds the highest priority, oldest first on ties
          out_d = cell_entry[0];
          if (req_i.action == ACT_DEQUEUE) begin
            ctrl.deq = fire;
            count_d  = count_q - CNT_BITS'(1);
          end
        end
      end
      default: begin
        // unused code: no change, report current level
        status_d = ST_OK;
      end
    endcase
  end

  // row of cells, each talking only to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occupied;
    logic   left_ahead;
    entry_t left_entry;
    entry_t right_entry;

    assign occupied = (CNT_BITS'(i) < count_q);

    if (i == 0) begin : g_head
      // nothing sits in front of the head cell
      assign left_ahead = 1'b1;
      assign left_entry = ctrl.new_entry;
    end else begin : g_body
      assign left_ahead = cell_ahead[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // tail content past the count is never read
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    apq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occupied),
      .left_ahead_i  (left_ahead),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .ahead_o       (cell_ahead[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      out_q    <= out_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_element  = out_q.elem;
  assign rsp_o.out_priority = out_q.prio;
  assign rsp_o.fill_level   = count_q;

  `include "array_priority_queue_unit_macros.svh"

  // an accepted enqueue on a non-full queue grows the row by one
  `APQ_ASSERT_NEXT(a_enq_grows, clk_i, rst_ni, fire && req_i.action == ACT_ENQUEUE && !full, count_q == $past(count_q) + CNT_BITS'(1), "enqueue did not grow the queue")

  // an accepted dequeue on a non-empty queue shrinks it by one
  `APQ_ASSERT_NEXT(a_deq_shrinks, clk_i, rst_ni, fire && req_i.action == ACT_DEQUEUE && !empty, count_q == $past(count_q) - CNT_BITS'(1), "dequeue did not shrink the queue")

  // a peek returns the head and leaves the row alone
  `APQ_ASSERT_NEXT(a_peek_head, clk_i, rst_ni, fire && req_i.action == ACT_PEEK && !empty, rsp_o.out_priority == $past(cell_entry[0].prio) && $stable(count_q), "peek result differs from head")

  // the row stays ordered by priority at its front
  `APQ_ASSERT_NOW(a_head_order, clk_i, rst_ni, count_q >= CNT_BITS'(2), cell_entry[0].prio >= cell_entry[1].prio, "head cell out of order")

  // the fill level never exceeds the capacity
  `APQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_BITS'(DEPTH), "fill level beyond capacity")

endmodule

`default_nettype wire
